[rtl/core/text_mode_pixel_generator_unit_macros.svh]
// Assertion macros for the text mode pixel generator
`ifndef TEXT_MODE_PIXEL_GENERATOR_UNIT_MACROS_SVH
`define TEXT_MODE_PIXEL_GENERATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// a holds in a cycle -> b holds in the same cycle
`define TMPG_ASSERT_IMPLY(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// a holds in a cycle -> b holds in the next cycle
`define TMPG_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`else

`define TMPG_ASSERT_IMPLY(label, clk, rst_n, a, b, msg)
`define TMPG_ASSERT_NEXT(label, clk, rst_n, a, b, msg)

`endif

`endif

[rtl/core/tmpg_pkg.sv]
// Types, constants and palette for the text mode pixel generator
package tmpg_pkg;

  localparam int CELL_SIZE       = 8;
  localparam int CELL_BITS       = 3;
  localparam int GLYPH_COUNT     = 128;
  localparam int NARROW_COLUMNS  = 40;
  localparam int DEF_TEXT_ROWS   = 25;
  localparam int DEF_MAX_COLUMNS = 80;
  localparam int SCREEN_DEPTH    = 2048;
  localparam int SCREEN_AW       = $clog2(SCREEN_DEPTH);
  localparam int GLYPH_DEPTH     = GLYPH_COUNT * CELL_SIZE;
  localparam int GLYPH_AW        = $clog2(GLYPH_DEPTH);
  localparam int CFG_DW          = 4;

  localparam logic [3:0] BG_RESET = 4'd6;

  typedef enum logic [1:0] {
    ACT_SCREEN = 2'd0,
    ACT_COLOUR = 2'd1,
    ACT_GLYPH  = 2'd2,
    ACT_PIXEL  = 2'd3
  } action_t;

  typedef enum logic {
    CFG_BACKGROUND   = 1'b0,
    CFG_WIDE_COLUMNS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    action_t     action;
    logic [10:0] store_address;
    logic [7:0]  write_byte;
    logic [9:0]  pixel_x;
    logic [7:0]  pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'hFFFFFF;
      4'd2:    rgb = 24'h880000;
      4'd3:    rgb = 24'hAAFFEE;
      4'd4:    rgb = 24'hCC44CC;
      4'd5:    rgb = 24'h00CC55;
      4'd6:    rgb = 24'h0000AA;
      4'd7:    rgb = 24'hEEEE77;
      4'd8:    rgb = 24'hDD8855;
      4'd9:    rgb = 24'h664400;
      4'd10:   rgb = 24'hFF7777;
      4'd11:   rgb = 24'h333333;
      4'd12:   rgb = 24'h777777;
      4'd13:   rgb = 24'hAAFF66;
      4'd14:   rgb = 24'h0088FF;
      default: rgb = 24'hBBBBBB;
    endcase
    return rgb;
  endfunction

endpackage

[rtl/core/text_mode_pixel_generator_unit.sv]
// Text mode pixel generator: four-stage pipeline from request to RGB
// Items pass through the stage 1, 2, 3 and output registers in turn.
// Throughput: one item per cycle when not stalled; screen/colour RAMs
// read in stage 2, glyph RAM in stage 3, palette in the output register.
// Stores are written at the stage where they are read, so order is kept.
// Reset (synchronous, rst_n low) clears valids and config; stores keep contents.
`include "text_mode_pixel_generator_unit_macros.svh"

module text_mode_pixel_generator_unit #(
  parameter int TEXT_ROWS   = tmpg_pkg::DEF_TEXT_ROWS,
  parameter int MAX_COLUMNS = tmpg_pkg::DEF_MAX_COLUMNS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  tmpg_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output tmpg_pkg::out_item_t        out_data,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [tmpg_pkg::CFG_DW-1:0] cfg_data
);

  import tmpg_pkg::*;

  localparam logic [6:0] NARROW_COLS = 7'(NARROW_COLUMNS);
  localparam logic [6:0] WIDE_COLS   = 7'(MAX_COLUMNS);
  localparam logic [9:0] ROW_LIMIT   = 10'(TEXT_ROWS * CELL_SIZE);

  // configuration
  logic [3:0] bg_r;
  logic       wide_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r   <= BG_RESET;
      wide_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BACKGROUND:   bg_r   <= cfg_data[3:0];
        CFG_WIDE_COLUMNS: wide_r <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 1: cell index and active-area check
  logic [6:0]  cols;
  logic [11:0] row_base;
  logic [12:0] cell_full;
  logic [SCREEN_AW-1:0] s1_cell_nxt;
  logic        s1_active_nxt;

  always_comb begin
    cols          = wide_r ? WIDE_COLS : NARROW_COLS;
    row_base      = {7'd0, in_data.pixel_y[7:CELL_BITS]} * {5'd0, cols};
    cell_full     = {1'b0, row_base} + {6'd0, in_data.pixel_x[9:CELL_BITS]};
    s1_cell_nxt   = cell_full[SCREEN_AW-1:0];
    s1_active_nxt = (in_data.pixel_x < {cols, 3'b000}) && ({2'd0, in_data.pixel_y} < ROW_LIMIT);
  end

  logic                 s1_vld_r;
  action_t              s1_act_r;
  logic [10:0]          s1_addr_r;
  logic [7:0]           s1_data_r;
  logic [SCREEN_AW-1:0] s1_cell_r;
  logic                 s1_active_r;
  logic [2:0]           s1_line_r;
  logic [2:0]           s1_bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
    end
    if (adv) begin
      s1_act_r    <= in_data.action;
      s1_addr_r   <= in_data.store_address;
      s1_data_r   <= in_data.write_byte;
      s1_cell_r   <= s1_cell_nxt;
      s1_active_r <= s1_active_nxt;
      s1_line_r   <= in_data.pixel_y[2:0];
      s1_bit_r    <= in_data.pixel_x[2:0];
    end
  end

  // stage 2: screen code and colour stores
  logic [SCREEN_AW-1:0] scr_addr;
  logic                 scr_we;
  logic                 col_we;
  logic [7:0]           s2_code;
  logic [3:0]           s2_colour;

  assign scr_addr = (s1_act_r == ACT_PIXEL) ? s1_cell_r : s1_addr_r[SCREEN_AW-1:0];
  assign scr_we   = s1_vld_r && adv && (s1_act_r == ACT_SCREEN);
  assign col_we   = s1_vld_r && adv && (s1_act_r == ACT_COLOUR);

  tmpg_ram #(.WIDTH(8), .DEPTH(SCREEN_DEPTH)) u_screen_ram (
    .clk   (clk),
    .we    (scr_we),
    .re    (adv),
    .addr  (scr_addr),
    .wdata (s1_data_r),
    .rdata (s2_code)
  );

  tmpg_ram #(.WIDTH(4), .DEPTH(SCREEN_DEPTH)) u_colour_ram (
    .clk   (clk),
    .we    (col_we),
    .re    (adv),
    .addr  (scr_addr),
    .wdata (s1_data_r[3:0]),
    .rdata (s2_colour)
  );

  logic        s2_vld_r;
  action_t     s2_act_r;
  logic [10:0] s2_addr_r;
  logic [7:0]  s2_data_r;
  logic        s2_active_r;
  logic [2:0]  s2_line_r;
  logic [2:0]  s2_bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
    if (adv) begin
      s2_act_r    <= s1_act_r;
      s2_addr_r   <= s1_addr_r;
      s2_data_r   <= s1_data_r;
      s2_active_r <= s1_active_r;
      s2_line_r   <= s1_line_r;
      s2_bit_r    <= s1_bit_r;
    end
  end

  // stage 3: glyph store
  logic [GLYPH_AW-1:0] gly_addr;
  logic                gly_we;
  logic [7:0]          s3_row;

  assign gly_addr = (s2_act_r == ACT_PIXEL) ? {s2_code[6:0], s2_line_r}
                                            : s2_addr_r[GLYPH_AW-1:0];
  assign gly_we   = s2_vld_r && adv && (s2_act_r == ACT_GLYPH)
                    && (s2_addr_r < 11'(GLYPH_DEPTH));

  tmpg_ram #(.WIDTH(8), .DEPTH(GLYPH_DEPTH)) u_glyph_ram (
    .clk   (clk),
    .we    (gly_we),
    .re    (adv),
    .addr  (gly_addr),
    .wdata (s2_data_r),
    .rdata (s3_row)
  );

  logic       s3_vld_r;
  action_t    s3_act_r;
  logic       s3_active_r;
  logic [2:0] s3_bit_r;
  logic       s3_inv_r;
  logic [3:0] s3_colour_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
    if (adv) begin
      s3_act_r    <= s2_act_r;
      s3_active_r <= s2_active_r;
      s3_bit_r    <= s2_bit_r;
      s3_inv_r    <= s2_code[7];
      s3_colour_r <= s2_colour;
    end
  end

  // stage 4: pixel select, palette, output register
  logic        lit;
  logic [3:0]  pal_idx;
  logic [23:0] rgb_nxt;
  logic        out_vld_nxt;

  always_comb begin
    lit         = s3_row[3'd7 - s3_bit_r] ^ s3_inv_r;
    pal_idx     = (s3_active_r && lit) ? s3_colour_r : bg_r;
    rgb_nxt     = palette_rgb(pal_idx);
    out_vld_nxt = s3_vld_r && (s3_act_r == ACT_PIXEL);
  end

  logic      out_vld_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= out_vld_nxt;
    end
    if (adv) begin
      out_data_r <= out_item_t'(rgb_nxt);
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  `TMPG_ASSERT_NEXT(a_pixel_reaches_output, clk, rst_n, s3_vld_r && adv && (s3_act_r == ACT_PIXEL), out_valid, "pixel request lost before output")
  `TMPG_ASSERT_NEXT(a_write_no_result, clk, rst_n, adv && !(s3_vld_r && (s3_act_r == ACT_PIXEL)), !out_valid, "result without pixel request")
  `TMPG_ASSERT_IMPLY(a_stall_backs_up, clk, rst_n, out_valid && out_stall, in_stall && !scr_we && !col_we && !gly_we, "pipeline moved while output stalled")

endmodule

[rtl/core/tmpg_ram.sv]
// Generic single-port RAM with registered read
module tmpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
